FILE: sv/crs_pkg.sv
// Shared types and constants of the coalescing range set.
package crs_pkg;

    localparam int KEY_W = 64;
    localparam int ADD_W = 32;
    localparam int RC_W  = 7;

    localparam logic [KEY_W-1:0] SIGN_FLIP = {1'b1, {(KEY_W-1){1'b0}}};

    typedef enum logic [0:0] {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LOW,
        ACT_HIGH,
        ACT_BRIDGE,
        ACT_INSERT
    } t_act;

    typedef struct packed {
        logic eval;
        logic apply;
        t_act act;
    } t_cell_ctrl;

    typedef struct packed {
        logic cov;
        logic join_low;
        logic join_high;
    } t_cell_flags;

endpackage

FILE: sv/crs_ifs.sv
// Item and result channel interfaces of the coalescing range set.
interface crs_item_if;
    logic                               valid;
    logic                               ready;
    logic [0:0]                         opcode;
    logic signed [crs_pkg::KEY_W-1:0]   frame;

    modport source (output valid, output opcode, output frame, input ready);
    modport sink (input valid, input opcode, input frame, output ready);
endinterface

interface crs_result_if;
    logic                       valid;
    logic                       ready;
    logic                       hit;
    logic                       table_full;
    logic [crs_pkg::RC_W-1:0]   range_count;
    logic [crs_pkg::ADD_W-1:0]  add_count;

    modport source (output valid, output hit, output table_full, output range_count,
                    output add_count, input ready);
    modport sink (input valid, input hit, input table_full, input range_count,
                  input add_count, output ready);
endinterface

FILE: sv/crs_cell.sv
// One cell of the sorted range row: holds one range and shifts with its neighbours.
module crs_cell (
    input  logic                          i_clk,
    input  crs_pkg::t_cell_ctrl           i_ctrl,
    input  logic [crs_pkg::KEY_W-1:0]     i_key,
    input  logic                          i_valid,
    input  logic                          i_le_left,
    input  logic                          i_le_right,
    input  logic [crs_pkg::KEY_W-1:0]     i_left_first,
    input  logic [crs_pkg::KEY_W-1:0]     i_left_last,
    input  logic [crs_pkg::KEY_W-1:0]     i_right_first,
    input  logic [crs_pkg::KEY_W-1:0]     i_right_last,
    output logic                          o_le,
    output logic [crs_pkg::KEY_W-1:0]     o_first,
    output logic [crs_pkg::KEY_W-1:0]     o_last,
    output crs_pkg::t_cell_flags          o_flags
);

    logic [crs_pkg::KEY_W-1:0] r_first;
    logic [crs_pkg::KEY_W-1:0] r_last;
    logic                      r_low;
    logic                      r_pos;
    logic                      r_ge;
    logic                      r_cov;
    logic                      r_jl;
    logic                      r_jh;
    logic                      w_low;
    logic                      w_pos;

    assign o_le    = i_valid & (r_first <= i_key);
    assign o_first = r_first;
    assign o_last  = r_last;

    // The cell just below the frame and the cell at its insertion point.
    assign w_low = o_le & ~i_le_right;
    assign w_pos = ~o_le & i_le_left;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.eval) begin
            r_low <= w_low;
            r_pos <= w_pos;
            r_ge  <= ~o_le;
            r_cov <= w_low & (r_last >= i_key);
            r_jl  <= w_low & (i_key != '0) & (r_last == i_key - 1'b1);
            r_jh  <= w_pos & i_valid & (i_key != '1) & (r_first == i_key + 1'b1);
        end
        if (i_ctrl.apply) begin
            case (i_ctrl.act)
                crs_pkg::ACT_BRIDGE: begin
                    if (r_low) begin
                        r_last <= i_right_last;
                    end else if (r_ge) begin
                        r_first <= i_right_first;
                        r_last  <= i_right_last;
                    end
                end
                crs_pkg::ACT_LOW: begin
                    if (r_low) begin
                        r_last <= i_key;
                    end
                end
                crs_pkg::ACT_HIGH: begin
                    if (r_pos) begin
                        r_first <= i_key;
                    end
                end
                crs_pkg::ACT_INSERT: begin
                    if (r_pos) begin
                        r_first <= i_key;
                        r_last  <= i_key;
                    end else if (r_ge) begin
                        r_first <= i_left_first;
                        r_last  <= i_left_last;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_flags.cov       = r_cov;
    assign o_flags.join_low  = r_jl;
    assign o_flags.join_high = r_jh;

endmodule

FILE: sv/coalescing_range_set_core.sv
// Top level of the coalescing range set: cell row, sequencer and result register.
//
//  Channel   Dir  Payload                                   Transfer
//  i_item    in   opcode, frame                             valid & ready
//  o_result  out  hit, table_full, range_count, add_count   valid & ready
//
// An item passes state S_EVAL, which compares the frame in every cell, then state
// S_APPLY, which merges, inserts or shifts the row and loads the result register. A
// new item is accepted in the update state of the one before while results are taken.
// A result not taken stalls the next item in its update cycle. Synchronous reset
// empties the table and clears the add counter; no clearing pass is needed.
module coalescing_range_set_core #(
    parameter int MAX_RANGES = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    crs_item_if.sink             i_item,
    crs_result_if.source         o_result
);

    localparam int CW = $clog2(MAX_RANGES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_APPLY
    } t_state;

    t_state                       r_state, n_state;
    logic [CW-1:0]                r_used, n_used;
    logic [crs_pkg::ADD_W-1:0]    r_adds, n_adds;
    logic [crs_pkg::KEY_W-1:0]    r_key, n_key;
    crs_pkg::t_op                 r_op, n_op;
    logic                         r_out_valid, n_out_valid;
    logic                         r_hit, n_hit;
    logic                         r_full, n_full;
    logic [crs_pkg::RC_W-1:0]     r_rc, n_rc;
    logic [crs_pkg::ADD_W-1:0]    r_oadds, n_oadds;

    logic                         w_adv;
    logic                         w_accept;
    crs_pkg::t_act                w_act;
    crs_pkg::t_cell_ctrl          w_ctrl;
    logic                         w_covered;
    logic                         w_jl;
    logic                         w_jh;

    logic [MAX_RANGES-1:0]        w_valid;
    logic [MAX_RANGES-1:0]        w_le;
    logic [MAX_RANGES-1:0]        w_cov;
    logic [MAX_RANGES-1:0]        w_jlv;
    logic [MAX_RANGES-1:0]        w_jhv;
    logic [crs_pkg::KEY_W-1:0]    w_first [MAX_RANGES];
    logic [crs_pkg::KEY_W-1:0]    w_last  [MAX_RANGES];
    crs_pkg::t_cell_flags         w_flags [MAX_RANGES];

    assign w_adv    = ~r_out_valid | o_result.ready;
    assign i_item.ready = (r_state == S_IDLE) | ((r_state == S_APPLY) & w_adv);
    assign w_accept = i_item.valid & i_item.ready;

    assign w_ctrl.eval  = (r_state == S_EVAL);
    assign w_ctrl.apply = (r_state == S_APPLY) & w_adv;
    assign w_ctrl.act   = w_act;

    genvar g;
    generate
        for (g = 0; g < MAX_RANGES; g++) begin : g_cell
            assign w_valid[g] = (r_used > CW'(g));
            assign w_cov[g]   = w_flags[g].cov;
            assign w_jlv[g]   = w_flags[g].join_low;
            assign w_jhv[g]   = w_flags[g].join_high;

            crs_cell u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (w_ctrl),
                .i_key         (r_key),
                .i_valid       (w_valid[g]),
                .i_le_left     ((g == 0) ? 1'b1 : w_le[(g == 0) ? 0 : g - 1]),
                .i_le_right    ((g == MAX_RANGES - 1) ? 1'b0 :
                                w_le[(g == MAX_RANGES - 1) ? g : g + 1]),
                .i_left_first  (w_first[(g == 0) ? 0 : g - 1]),
                .i_left_last   (w_last[(g == 0) ? 0 : g - 1]),
                .i_right_first (w_first[(g == MAX_RANGES - 1) ? g : g + 1]),
                .i_right_last  (w_last[(g == MAX_RANGES - 1) ? g : g + 1]),
                .o_le          (w_le[g]),
                .o_first       (w_first[g]),
                .o_last        (w_last[g]),
                .o_flags       (w_flags[g])
            );
        end
    endgenerate

    assign w_covered = |w_cov;
    assign w_jl      = |w_jlv;
    assign w_jh      = |w_jhv;

    always_comb begin
        w_act = crs_pkg::ACT_NONE;
        if (r_op == crs_pkg::OP_ADD && !w_covered) begin
            if (w_jl && w_jh) begin
                w_act = crs_pkg::ACT_BRIDGE;
            end else if (w_jl) begin
                w_act = crs_pkg::ACT_LOW;
            end else if (w_jh) begin
                w_act = crs_pkg::ACT_HIGH;
            end else if (r_used < CW'(MAX_RANGES)) begin
                w_act = crs_pkg::ACT_INSERT;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_adds      = r_adds;
        n_key       = r_key;
        n_op        = r_op;
        n_out_valid = r_out_valid & ~o_result.ready;
        n_hit       = r_hit;
        n_full      = r_full;
        n_rc        = r_rc;
        n_oadds     = r_oadds;
        case (r_state)
            S_IDLE: begin
            end
            S_EVAL: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (w_adv) begin
                    n_state = S_IDLE;
                    if (r_op == crs_pkg::OP_ADD && r_adds != '1) begin
                        n_adds = r_adds + 1'b1;
                    end
                    if (w_act == crs_pkg::ACT_BRIDGE) begin
                        n_used = r_used - 1'b1;
                    end else if (w_act == crs_pkg::ACT_INSERT) begin
                        n_used = r_used + 1'b1;
                    end
                    n_out_valid = 1'b1;
                    n_hit       = w_covered;
                    n_full      = (r_op == crs_pkg::OP_ADD) & ~w_covered & ~w_jl & ~w_jh &
                                  (r_used >= CW'(MAX_RANGES));
                    n_rc        = crs_pkg::RC_W'(n_used);
                    n_oadds     = n_adds;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_accept) begin
            n_state = S_EVAL;
            n_key   = i_item.frame ^ crs_pkg::SIGN_FLIP;
            n_op    = crs_pkg::t_op'(i_item.opcode);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_adds      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_adds      <= n_adds;
            r_out_valid <= n_out_valid;
        end
        r_key   <= n_key;
        r_op    <= n_op;
        r_hit   <= n_hit;
        r_full  <= n_full;
        r_rc    <= n_rc;
        r_oadds <= n_oadds;
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.hit         = r_hit;
    assign o_result.table_full  = r_full;
    assign o_result.range_count = r_rc;
    assign o_result.add_count   = r_oadds;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(MAX_RANGES))
        else $error("Range count exceeds the table size.");

    a_result_from_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_APPLY))
        else $error("Result loaded outside the update cycle.");

    a_single_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY) |-> ($onehot0(w_cov) && $onehot0(w_jlv) && $onehot0(w_jhv)))
        else $error("More than one cell claims the frame position.");

    a_full_not_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_full) |-> !r_hit)
        else $error("Dropped add reported as already covered.");

endmodule
